// ----- hdl/u8d_pkg.sv -----
// u8d_pkg: types and constants shared by the UTF-8 byte stream decoder.
// No dependencies; compiled first.
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned COUNT_W = 3;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'h1f;
    localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'h0f;
    localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_LEAD5  = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_LEAD6  = 8'h01;
    localparam logic [BYTE_W-1:0] MASK_CONT   = 8'h3f;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              string_end;
    } byte_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
    } cp_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pending_count;
        logic [CP_W-1:0]    accumulator;
    } seq_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        seq_state_t      state;
    } step_t;

endpackage

`default_nettype wire

// ----- hdl/u8d_stream_if.sv -----
// u8d_stream_if: valid/ready channel carrying one beat of a given payload type.
// Depends on u8d_pkg for the payload types used at instantiation.
`default_nettype none

interface u8d_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- hdl/u8d_decode.sv -----
// u8d_decode: combinational step of the decoder, next sequence state and result.
// Depends on u8d_pkg.
`default_nettype none

module u8d_decode (
    input  wire u8d_pkg::byte_beat_t beat,
    input  wire u8d_pkg::seq_state_t cur,
    output u8d_pkg::step_t           step
);
    import u8d_pkg::*;

    logic [COUNT_W-1:0] count_dec;
    logic [CP_W-1:0]    acc_shift;

    assign count_dec = cur.pending_count - COUNT_W'(1);
    assign acc_shift = {cur.accumulator[CP_W-7:0], beat.data_byte[5:0] & MASK_CONT[5:0]};

    always_comb
    begin
        step = '0;
        step.state = cur;
        if (beat.string_end)
        begin
            step.state = '0;
        end
        else if (beat.data_byte < ASCII_LIMIT)
        begin
            step.state      = '0;
            step.emit       = 1'b1;
            step.code_point = CP_W'(beat.data_byte);
        end
        else if (cur.pending_count == '0)
        begin
            unique case (beat.data_byte) inside
                [8'h80:8'hbf]:
                begin
                    step.state = cur;
                end
                [8'hc0:8'hdf]:
                begin
                    step.state.pending_count = COUNT_W'(1);
                    step.state.accumulator   = CP_W'(beat.data_byte & MASK_LEAD2);
                end
                [8'he0:8'hef]:
                begin
                    step.state.pending_count = COUNT_W'(2);
                    step.state.accumulator   = CP_W'(beat.data_byte & MASK_LEAD3);
                end
                [8'hf0:8'hf7]:
                begin
                    step.state.pending_count = COUNT_W'(3);
                    step.state.accumulator   = CP_W'(beat.data_byte & MASK_LEAD4);
                end
                [8'hf8:8'hfb]:
                begin
                    step.state.pending_count = COUNT_W'(4);
                    step.state.accumulator   = CP_W'(beat.data_byte & MASK_LEAD5);
                end
                default:
                begin
                    step.state.pending_count = COUNT_W'(5);
                    step.state.accumulator   = CP_W'(beat.data_byte & MASK_LEAD6);
                end
            endcase
        end
        else
        begin
            step.state.pending_count = count_dec;
            step.state.accumulator   = acc_shift;
            step.emit                = (count_dec == '0);
            step.code_point          = acc_shift;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/u8d_out_stage.sv -----
// u8d_out_stage: result register driving the code point channel.
// Depends on u8d_pkg and u8d_stream_if.
`default_nettype none

module u8d_out_stage (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  wire u8d_pkg::step_t step,
    output logic              slot_free,
    u8d_stream_if.source      chars
);
    import u8d_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CP_W-1:0] cp_reg;

    assign slot_free  = !valid_reg || chars.ready;
    assign valid_next = load ? step.emit : (valid_reg && !chars.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && step.emit)
        begin
            cp_reg <= step.code_point;
        end
    end

    assign chars.valid              = valid_reg;
    assign chars.payload.code_point = cp_reg;

endmodule

`default_nettype wire

// ----- hdl/utf8_byte_stream_decoder_unit.sv -----
// utf8_byte_stream_decoder_unit: lenient UTF-8 decoder, legacy six-byte form.
// Each byte passes the input register, then the result register that drives chars. One byte per
// cycle is taken while the result register is free or chars is ready.
// A result held while chars is not ready stalls bytes. Reset (rst_n, async, active low)
// clears the pending sequence and both valids. Depends on u8d_pkg, u8d_stream_if, u8d_decode, u8d_out_stage.
`default_nettype none

module utf8_byte_stream_decoder_unit (
    input  wire          clk,
    input  wire          rst_n,
    u8d_stream_if.sink   bytes,
    u8d_stream_if.source chars
);
    import u8d_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    byte_beat_t in_beat_reg;
    seq_state_t seq_reg;
    step_t      step;
    logic       slot_free;
    logic       advance;

    assign advance       = in_valid_reg && slot_free;
    assign bytes.ready   = !in_valid_reg || advance;
    assign in_valid_next = bytes.valid || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            seq_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                seq_reg <= step.state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_beat_reg <= bytes.payload;
        end
    end

    u8d_decode u_decode (
        .beat (in_beat_reg),
        .cur  (seq_reg),
        .step (step)
    );

    u8d_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .step      (step),
        .slot_free (slot_free),
        .chars     (chars)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.pending_count <= COUNT_W'(5))
        else $error("pending count out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_beat_reg.string_end |=> seq_reg == '0 && !chars.valid)
        else $error("string end did not clear sequence or produced a result");

    a_ascii_emit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_beat_reg.string_end && !in_beat_reg.data_byte[7]
        |=> chars.valid && chars.payload.code_point == CP_W'($past(in_beat_reg.data_byte)))
        else $error("ASCII byte not emitted");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && !chars.ready |=> chars.valid && $stable(chars.payload))
        else $error("pending result lost");

endmodule

`default_nettype wire
